// ----- src/slfa_pkg.sv -----
// ----------------------------------------------------------------------------
// slfa_pkg
// Shared types and codes of the slot free list allocator: operation and
// status codes, controller states, and the input and result transfer structs.
// ----------------------------------------------------------------------------
`default_nettype none

package slfa_pkg;

  typedef logic [2:0] op_t;
  typedef logic [1:0] stat_t;

  localparam op_t OP_INIT      = 3'd0;
  localparam op_t OP_FREE_SLOT = 3'd1;
  localparam op_t OP_FREE_POS  = 3'd2;
  localparam op_t OP_COMPACT   = 3'd3;
  localparam op_t OP_ALLOC     = 3'd4;

  localparam stat_t STAT_OK        = 2'd0;
  localparam stat_t STAT_NOT_LIVE  = 2'd1;
  localparam stat_t STAT_POOL_FULL = 2'd2;
  localparam stat_t STAT_BAD_POS   = 2'd3;

  // register index, taken from the address bit above the word offset
  localparam logic REG_INIT_GROUPS = 1'b0;
  localparam logic REG_INIT_SIZE   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_PASS,
    S_GAP,
    S_ALLOC,
    S_REL_RD,
    S_REL_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] slot_in;
    logic [7:0] position_in;
    logic [3:0] group_in;
  } in_t;

  typedef struct packed {
    logic [7:0] slot_out;
    logic [1:0] status;
    logic [8:0] live_total;
    logic [8:0] group_total;
  } out_t;

endpackage

`default_nettype wire

// ----- src/slfa_cell.sv -----
// ----------------------------------------------------------------------------
// slfa_cell
// One live list entry: a valid bit over a slot number. Takes its neighbor's
// entry when the ring rotates, or a direct write while the ring rests.
// ----------------------------------------------------------------------------
`default_nettype none

module slfa_cell #(
  parameter int EW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire logic [EW-1:0] nb_in,
  input  wire logic          wr_en,
  input  wire logic [EW-1:0] wr_data,
  output logic      [EW-1:0] q
);

  logic [EW-1:0] ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (shift_en) begin
      ent_r <= nb_in;
    end else if (wr_en) begin
      ent_r <= wr_data;
    end
  end

  assign q = ent_r;

endmodule

`default_nettype wire

// ----- src/slfa_chain.sv -----
// ----------------------------------------------------------------------------
// slfa_chain
// Ring of live list cells. Each rotation step moves every entry one cell
// toward cell 0; the entry leaving cell 0 re-enters at the far end, possibly
// rewritten. A full turn of N steps brings every entry home.
// ----------------------------------------------------------------------------
`default_nettype none

module slfa_chain #(
  parameter int N  = 256,
  parameter int SW = 8,
  parameter int EW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire logic [EW-1:0] head_in,
  input  wire logic          wr_en,
  input  wire logic [SW-1:0] wr_idx,
  input  wire logic [EW-1:0] wr_data,
  output logic      [EW-1:0] head_out
);

  logic [EW-1:0] q [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [EW-1:0] nb;
    if (i == N - 1) begin : g_tail
      assign nb = head_in;
    end else begin : g_mid
      assign nb = q[i+1];
    end
    slfa_cell #(.EW(EW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .nb_in    (nb),
      .wr_en    (wr_en && (wr_idx == SW'(i))),
      .wr_data  (wr_data),
      .q        (q[i])
    );
  end

  assign head_out = q[0];

endmodule

`default_nettype wire

// ----- src/slot_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// slot_free_list_allocator
// Slot pool with a live list held in a ring of cells, a free stack, the
// group of each slot and a live count per group.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | slfa_pkg::in_t
//  out_    | output    | out_valid / out_stall  | slfa_pkg::out_t
//  cfg_    | input     | APB write, pready high | init_groups, init_group_size
//
//  Initialize and free by position walk the live list ring once; free by
//  slot walks it a second time, to close the gap, only when the slot is
//  live; compact walks it to count, to lift and to refill; allocate none.
//  Each full walk is one turn of the live list ring, one entry per cycle.
//  One item is worked at a time; the next is taken once the result sits in
//  the output register, even while that result is stalled.
//  Synchronous active-low reset empties the live list and zeroes counts.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_free_list_allocator #(
  parameter int MAX_SLOTS  = 256,
  parameter int MAX_GROUPS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire slfa_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output slfa_pkg::out_t      out_data,
  input  wire logic           cfg_psel,
  input  wire logic           cfg_penable,
  input  wire logic           cfg_pwrite,
  input  wire logic [2:0]     cfg_paddr,
  input  wire logic [31:0]    cfg_pwdata,
  output logic      [31:0]    cfg_prdata,
  output logic                cfg_pready
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int EW = SW + 1;

  function automatic logic [GW-1:0] grp_mod(input logic [3:0] v);
    logic [GW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v == 4'(i)) r = GW'(i % MAX_GROUPS);
    end
    return r;
  endfunction

  // configuration
  logic [4:0] cfg_groups_r;
  logic [8:0] cfg_size_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_groups_r <= 5'd4;
      cfg_size_r   <= 9'd16;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        slfa_pkg::REG_INIT_GROUPS: cfg_groups_r <= cfg_pwdata[4:0];
        slfa_pkg::REG_INIT_SIZE:   cfg_size_r   <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      slfa_pkg::REG_INIT_GROUPS: cfg_prdata = {27'd0, cfg_groups_r};
      slfa_pkg::REG_INIT_SIZE:   cfg_prdata = {23'd0, cfg_size_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  // control and datapath registers
  slfa_pkg::state_t state_r, state_nxt;
  slfa_pkg::in_t    item_r;
  logic [1:0]    phase_r, phase_nxt;
  logic [SW-1:0] k_r, k_nxt;
  logic [CW-1:0] live_top_r, live_top_nxt;
  logic [CW-1:0] free_depth_r, free_depth_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [GW-1:0] gi_r, gi_nxt;
  logic [8:0]    h_r, h_nxt;
  logic          found_r, found_nxt;
  logic          hit_r, hit_nxt;
  logic [SW-1:0] a_r, a_nxt;
  logic [EW-1:0] tent_r, tent_nxt;
  logic [SW-1:0] rel_s_r, rel_s_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [7:0]    res_slot_r, res_slot_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic [CW-1:0] res_gt_r, res_gt_nxt;
  logic          out_valid_r, out_valid_nxt;
  slfa_pkg::out_t out_data_r, out_data_nxt;

  // memories
  logic [SW-1:0] fs_mem [MAX_SLOTS];
  logic [GW-1:0] sg_mem [MAX_SLOTS];
  logic [SW-1:0] cs_mem [MAX_SLOTS];
  logic [SW-1:0] fs_q, cs_q;
  logic [GW-1:0] sg_q;
  logic          fs_we, sg_we, cs_we;
  logic [SW-1:0] fs_waddr, sg_waddr, cs_waddr, fs_wdata, cs_wdata;
  logic [GW-1:0] sg_wdata;
  logic [CW-1:0] fs_rptr, cs_rptr;

  // group counts
  logic [CW-1:0] cnt_r [MAX_GROUPS];
  logic          cnt_clr, cnt_we;
  logic [GW-1:0] cnt_idx;
  logic [CW-1:0] cnt_rd, cnt_wdata;

  // live list ring
  logic          shift_en, chain_we;
  logic [EW-1:0] head_in, head_out, chain_wdata;
  logic [SW-1:0] chain_widx;
  logic          hv;
  logic [SW-1:0] hs;
  logic [CW-1:0] posk;
  logic          last_k;
  logic          accept;

  slfa_chain #(.N(MAX_SLOTS), .SW(SW), .EW(EW)) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .head_in  (head_in),
    .wr_en    (chain_we),
    .wr_idx   (chain_widx),
    .wr_data  (chain_wdata),
    .head_out (head_out)
  );

  assign hv     = head_out[SW];
  assign hs     = head_out[SW-1:0];
  assign posk   = CW'(k_r);
  assign last_k = (k_r == SW'(MAX_SLOTS - 1));
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != slfa_pkg::S_IDLE);
  assign cnt_rd = cnt_r[cnt_idx];

  // initial total, saturated at the pool size
  logic [4:0]  grp_lim;
  logic [13:0] init_prod;
  assign grp_lim   = (32'(cfg_groups_r) > MAX_GROUPS) ? 5'(MAX_GROUPS) : cfg_groups_r;
  assign init_prod = 14'(grp_lim) * 14'(cfg_size_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slfa_pkg::S_IDLE: begin
        if (accept) state_nxt = slfa_pkg::S_SETUP;
      end
      slfa_pkg::S_SETUP: begin
        case (item_r.operation)
          slfa_pkg::OP_INIT,
          slfa_pkg::OP_FREE_SLOT,
          slfa_pkg::OP_FREE_POS,
          slfa_pkg::OP_COMPACT: state_nxt = slfa_pkg::S_PASS;
          slfa_pkg::OP_ALLOC: begin
            if (free_depth_r == '0 || live_top_r >= CW'(MAX_SLOTS)) begin
              state_nxt = slfa_pkg::S_DONE;
            end else begin
              state_nxt = slfa_pkg::S_ALLOC;
            end
          end
          default: state_nxt = slfa_pkg::S_DONE;
        endcase
      end
      slfa_pkg::S_PASS: begin
        if (last_k) begin
          case (item_r.operation)
            slfa_pkg::OP_FREE_SLOT: begin
              if (phase_r != 2'd0) state_nxt = slfa_pkg::S_REL_RD;
              else if (found_nxt)  state_nxt = slfa_pkg::S_PASS;
              else                 state_nxt = slfa_pkg::S_DONE;
            end
            slfa_pkg::OP_FREE_POS: begin
              state_nxt = hit_nxt ? slfa_pkg::S_REL_RD : slfa_pkg::S_DONE;
            end
            slfa_pkg::OP_COMPACT: begin
              case (phase_r)
                2'd0:    state_nxt = slfa_pkg::S_PASS;
                2'd1:    state_nxt = slfa_pkg::S_GAP;
                default: state_nxt = slfa_pkg::S_DONE;
              endcase
            end
            default: state_nxt = slfa_pkg::S_DONE;
          endcase
        end
      end
      slfa_pkg::S_GAP:    state_nxt = slfa_pkg::S_PASS;
      slfa_pkg::S_ALLOC:  state_nxt = slfa_pkg::S_DONE;
      slfa_pkg::S_REL_RD: state_nxt = slfa_pkg::S_REL_WR;
      slfa_pkg::S_REL_WR: state_nxt = slfa_pkg::S_DONE;
      slfa_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = slfa_pkg::S_IDLE;
      end
      default: state_nxt = slfa_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt      = phase_r;
    k_nxt          = k_r;
    live_top_nxt   = live_top_r;
    free_depth_nxt = free_depth_r;
    total_nxt      = total_r;
    gi_nxt         = gi_r;
    h_nxt          = h_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    a_nxt          = a_r;
    tent_nxt       = tent_r;
    rel_s_nxt      = rel_s_r;
    n_nxt          = n_r;
    sp_nxt         = sp_r;
    res_slot_nxt   = res_slot_r;
    res_st_nxt     = res_st_r;
    res_gt_nxt     = res_gt_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    shift_en       = 1'b0;
    head_in        = head_out;
    chain_we       = 1'b0;
    chain_widx     = live_top_r[SW-1:0];
    chain_wdata    = '0;
    fs_we          = 1'b0;
    fs_waddr       = k_r;
    fs_wdata       = '0;
    sg_we          = 1'b0;
    sg_waddr       = k_r;
    sg_wdata       = gi_r;
    cs_we          = 1'b0;
    cs_waddr       = sp_r[SW-1:0];
    cs_wdata       = hs;
    cnt_clr        = 1'b0;
    cnt_we         = 1'b0;
    cnt_idx        = gi_r;
    cnt_wdata      = '0;

    case (state_r)
      slfa_pkg::S_SETUP: begin
        phase_nxt    = 2'd0;
        k_nxt        = '0;
        found_nxt    = 1'b0;
        hit_nxt      = 1'b0;
        n_nxt        = '0;
        sp_nxt       = '0;
        gi_nxt       = '0;
        h_nxt        = '0;
        res_slot_nxt = '0;
        res_st_nxt   = slfa_pkg::STAT_OK;
        res_gt_nxt   = '0;
        if (item_r.operation == slfa_pkg::OP_INIT) begin
          cnt_clr   = 1'b1;
          total_nxt = (32'(init_prod) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(init_prod);
        end
        if (item_r.operation == slfa_pkg::OP_ALLOC &&
            (free_depth_r == '0 || live_top_r >= CW'(MAX_SLOTS))) begin
          res_st_nxt = slfa_pkg::STAT_POOL_FULL;
        end
      end

      slfa_pkg::S_PASS: begin
        shift_en = 1'b1;
        k_nxt    = last_k ? '0 : k_r + SW'(1);
        if (last_k) phase_nxt = phase_r + 2'd1;
        case (item_r.operation)
          slfa_pkg::OP_INIT: begin
            if (posk < total_r) begin
              head_in   = {1'b1, k_r};
              sg_we     = 1'b1;
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rd + CW'(1);
              if (h_r + 9'd1 == cfg_size_r) begin
                h_nxt  = '0;
                gi_nxt = gi_r + GW'(1);
              end else begin
                h_nxt = h_r + 9'd1;
              end
            end else begin
              head_in = '0;
            end
            if (posk < CW'(MAX_SLOTS) - total_r) begin
              fs_we    = 1'b1;
              fs_wdata = SW'(MAX_SLOTS - 1) - k_r;
            end
            if (last_k) begin
              live_top_nxt   = total_r;
              free_depth_nxt = CW'(MAX_SLOTS) - total_r;
            end
          end
          slfa_pkg::OP_FREE_SLOT: begin
            if (phase_r == 2'd0) begin
              if (!found_r && hv && posk < live_top_r &&
                  32'(hs) == 32'(item_r.slot_in)) begin
                found_nxt = 1'b1;
                a_nxt     = k_r;
                rel_s_nxt = hs;
              end
              if (posk == live_top_r - CW'(1)) tent_nxt = head_out;
              if (last_k && !found_nxt) res_st_nxt = slfa_pkg::STAT_NOT_LIVE;
            end else begin
              // top entry fills the gap, then the top cell empties
              if (posk == live_top_r - CW'(1)) head_in = '0;
              else if (k_r == a_r)             head_in = tent_r;
              if (last_k) live_top_nxt = live_top_r - CW'(1);
            end
          end
          slfa_pkg::OP_FREE_POS: begin
            if (32'(k_r) == 32'(item_r.position_in) && posk < live_top_r && hv) begin
              head_in   = '0;
              hit_nxt   = 1'b1;
              rel_s_nxt = hs;
            end
            if (last_k && !hit_nxt) res_st_nxt = slfa_pkg::STAT_BAD_POS;
          end
          slfa_pkg::OP_COMPACT: begin
            case (phase_r)
              2'd0: begin
                if (hv) n_nxt = n_r + CW'(1);
              end
              2'd1: begin
                // lift entries above the compacted length onto the stack
                if (posk >= n_r && hv) begin
                  cs_we   = 1'b1;
                  sp_nxt  = sp_r + CW'(1);
                  head_in = '0;
                end
              end
              default: begin
                // holes take the highest entries first
                if (posk < n_r && !hv) begin
                  head_in = {1'b1, cs_q};
                  sp_nxt  = sp_r - CW'(1);
                end
                if (last_k) live_top_nxt = n_r;
              end
            endcase
          end
          default: ;
        endcase
      end

      slfa_pkg::S_ALLOC: begin
        cnt_idx        = grp_mod(item_r.group_in);
        free_depth_nxt = free_depth_r - CW'(1);
        sg_we          = 1'b1;
        sg_waddr       = fs_q;
        sg_wdata       = cnt_idx;
        chain_we       = 1'b1;
        chain_wdata    = {1'b1, fs_q};
        live_top_nxt   = live_top_r + CW'(1);
        cnt_we         = 1'b1;
        cnt_wdata      = (cnt_rd < CW'(MAX_SLOTS)) ? cnt_rd + CW'(1) : cnt_rd;
        res_gt_nxt     = cnt_wdata;
        res_slot_nxt   = 8'(fs_q);
      end

      slfa_pkg::S_REL_WR: begin
        cnt_idx      = sg_q;
        cnt_we       = 1'b1;
        cnt_wdata    = (cnt_rd == '0) ? '0 : cnt_rd - CW'(1);
        res_gt_nxt   = cnt_wdata;
        res_slot_nxt = 8'(rel_s_r);
        if (free_depth_r < CW'(MAX_SLOTS)) begin
          fs_we          = 1'b1;
          fs_waddr       = free_depth_r[SW-1:0];
          fs_wdata       = rel_s_r;
          free_depth_nxt = free_depth_r + CW'(1);
        end
      end

      slfa_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.slot_out    = res_slot_r;
          out_data_nxt.status      = res_st_r;
          out_data_nxt.live_total  = 9'(live_top_r);
          out_data_nxt.group_total = 9'(res_gt_r);
        end
      end

      default: ;
    endcase
  end

  assign fs_rptr = free_depth_r - CW'(1);
  assign cs_rptr = sp_nxt - CW'(1);

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    fs_q <= fs_mem[fs_rptr[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sg_we) sg_mem[sg_waddr] <= sg_wdata;
    sg_q <= sg_mem[rel_s_r];
  end

  always_ff @(posedge clk) begin
    if (cs_we) cs_mem[cs_waddr] <= cs_wdata;
    cs_q <= cs_mem[cs_rptr[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < MAX_GROUPS; g++) cnt_r[g] <= '0;
    end else if (cnt_clr) begin
      for (int g = 0; g < MAX_GROUPS; g++) cnt_r[g] <= '0;
    end else if (cnt_we) begin
      cnt_r[cnt_idx] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= slfa_pkg::S_IDLE;
      out_valid_r  <= 1'b0;
      live_top_r   <= '0;
      free_depth_r <= '0;
      phase_r      <= '0;
      k_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      live_top_r   <= live_top_nxt;
      free_depth_r <= free_depth_nxt;
      phase_r      <= phase_nxt;
      k_r          <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    total_r    <= total_nxt;
    gi_r       <= gi_nxt;
    h_r        <= h_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    a_r        <= a_nxt;
    tent_r     <= tent_nxt;
    rel_s_r    <= rel_s_nxt;
    n_r        <= n_nxt;
    sp_r       <= sp_nxt;
    res_slot_r <= res_slot_nxt;
    res_st_r   <= res_st_nxt;
    res_gt_r   <= res_gt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- src/slfa_check.sv -----
// ----------------------------------------------------------------------------
// slfa_check
// Port-level checks of the slot free list allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slfa_check #(
  parameter int MAX_SLOTS = 256
) (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire slfa_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire slfa_pkg::out_t out_data
);

  // one item at a time: a transfer in closes the input until its result
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in work");

  // failed operations report no slot
  a_slot_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != slfa_pkg::STAT_OK) |-> (out_data.slot_out == 8'd0))
    else $error("slot reported with an error status");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.live_total) <= MAX_SLOTS))
    else $error("live total above pool size");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind slot_free_list_allocator slfa_check #(.MAX_SLOTS(MAX_SLOTS)) u_slfa_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
